// ===== sv/mfhr_pkg.sv =====
package mfhr_pkg;

	localparam logic [1:0] CMD_SAVE  = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_COUNT = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [1:0] COUNT_MAX = 2'd3;

	typedef logic [1:0] command_t;

endpackage

// ===== sv/mfhr_ram.sv =====
module mfhr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 9
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/multi_folder_history_ring_core.sv =====
// Multi-folder history ring.
// Input channel (in_valid/in_ready) carries one command per transaction:
// save, load by age, count valid slots, or clear, aimed at one folder.
// Output channel (out_valid/out_ready) returns exactly one result per
// command: found, message_out and stored_count.
// out_valid rises in the cycle after input acceptance for save and for a
// bad folder; load first passes through one registered read of the message
// RAM and ST_READ; count and clear pass through ST_WALK, which steps through the
// folder's valid bits one slot per cycle with a single index counter.
// One command is in flight at a time; in_ready rises again in the cycle
// after the result is taken, so no new command is accepted before the
// previous result has been taken.
// While out_ready is low the result is held unchanged and no new command
// is accepted.
// Reset clears every valid bit and write pointer at once; message RAM
// contents are not reset, and data from an unsaved slot is never returned.
module multi_folder_history_ring_core #(
	parameter int HISTORY_DEPTH = 3,
	parameter int FOLDER_COUNT  = 3,
	parameter int PAYLOAD_WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               command,
	input  logic [1:0]               folder,
	input  logic [1:0]               age,
	input  logic [PAYLOAD_WIDTH-1:0] message_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     found,
	output logic [PAYLOAD_WIDTH-1:0] message_out,
	output logic [1:0]               stored_count
);

	localparam int SLOTS = FOLDER_COUNT * HISTORY_DEPTH;
	localparam int AW    = $clog2(SLOTS);
	localparam int PW    = $clog2(HISTORY_DEPTH);
	localparam int FW    = (FOLDER_COUNT > 1) ? $clog2(FOLDER_COUNT) : 1;
	localparam int CW    = $clog2(HISTORY_DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]               state_q;
	mfhr_pkg::command_t       cmd_q;
	logic [FW-1:0]            fsel_q;
	logic [AW-1:0]            base_q;
	logic [PW-1:0]            idx_q;
	logic [CW-1:0]            acc_q;
	logic                     hit_q;
	logic [SLOTS-1:0]         valid_q;
	logic [PW-1:0]            wptr_q [FOLDER_COUNT];
	logic                     found_q;
	logic [PAYLOAD_WIDTH-1:0] msg_q;
	logic [1:0]               cnt_q;

	logic                     accept;
	logic                     folder_ok;
	logic                     age_ok;
	logic [FW-1:0]            fsel;
	logic [AW-1:0]            base;
	logic [PW-1:0]            ptr;
	logic [PW:0]              back_sum;
	logic [PW-1:0]            load_slot;
	logic [AW-1:0]            load_addr;
	logic [AW-1:0]            save_addr;
	logic [AW-1:0]            walk_addr;
	logic                     walk_bit;
	logic                     walk_last;
	logic [CW-1:0]            total;
	logic                     ram_wr;
	logic [PAYLOAD_WIDTH-1:0] ram_rd_data;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign folder_ok = ({30'd0, folder} < 32'(FOLDER_COUNT));
	assign age_ok    = ({30'd0, age} < 32'(HISTORY_DEPTH));
	assign fsel      = FW'(folder);
	assign base      = AW'(AW'(fsel) * AW'(HISTORY_DEPTH));
	assign ptr       = wptr_q[fsel];
	assign back_sum  = (PW+1)'(ptr) + (PW+1)'(HISTORY_DEPTH - 1) - (PW+1)'(age);
	assign load_slot = (back_sum >= (PW+1)'(HISTORY_DEPTH))
		? PW'(back_sum - (PW+1)'(HISTORY_DEPTH)) : PW'(back_sum);
	assign load_addr = base + AW'(load_slot);
	assign save_addr = base + AW'(ptr);
	assign walk_addr = base_q + AW'(idx_q);
	assign walk_bit  = valid_q[walk_addr];
	assign walk_last = (idx_q == PW'(HISTORY_DEPTH - 1));
	assign total     = acc_q + CW'(walk_bit);
	assign ram_wr    = accept && folder_ok && (command == mfhr_pkg::CMD_SAVE);

	mfhr_ram #(
		.WIDTH(PAYLOAD_WIDTH),
		.DEPTH(SLOTS)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr),
		.wr_addr(save_addr),
		.wr_data(message_in),
		.rd_addr(load_addr),
		.rd_data(ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			for (int i = 0; i < FOLDER_COUNT; i++) begin
				wptr_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!folder_ok) begin
							state_q <= ST_DONE;
						end else begin
							case (command)
								mfhr_pkg::CMD_SAVE: begin
									valid_q[save_addr] <= 1'b1;
									wptr_q[fsel] <= (ptr == PW'(HISTORY_DEPTH - 1))
										? '0 : ptr + PW'(1);
									state_q <= ST_DONE;
								end
								mfhr_pkg::CMD_LOAD: begin
									state_q <= ST_READ;
								end
								default: begin
									state_q <= ST_WALK;
								end
							endcase
						end
					end
				end
				ST_WALK: begin
					if (cmd_q == mfhr_pkg::CMD_CLEAR) begin
						valid_q[walk_addr] <= 1'b0;
					end
					if (walk_last) begin
						if (cmd_q == mfhr_pkg::CMD_CLEAR) begin
							wptr_q[fsel_q] <= '0;
						end
						state_q <= ST_DONE;
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q   <= command;
				fsel_q  <= fsel;
				base_q  <= base;
				idx_q   <= '0;
				acc_q   <= '0;
				hit_q   <= age_ok && valid_q[load_addr];
				found_q <= folder_ok;
				msg_q   <= '0;
				cnt_q   <= '0;
			end
			ST_WALK: begin
				idx_q <= idx_q + PW'(1);
				acc_q <= total;
				if (walk_last && (cmd_q == mfhr_pkg::CMD_COUNT)) begin
					cnt_q <= (total > CW'(mfhr_pkg::COUNT_MAX))
						? mfhr_pkg::COUNT_MAX : total[1:0];
				end
			end
			ST_READ: begin
				found_q <= hit_q;
				msg_q   <= hit_q ? ram_rd_data : '0;
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = (state_q == ST_DONE);
	assign found        = found_q;
	assign message_out  = msg_q;
	assign stored_count = cnt_q;

endmodule
